### src/cau_pkg.sv
// Package for the complex arithmetic unit: action codes and the control word
// that travels with each transaction down the pipeline. No dependencies.
`default_nettype none
package cau_pkg;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
        logic side_ovf;
    } cau_ctl_t;

endpackage
`default_nettype wire

### src/cau_if.sv
// Valid/ready channel interfaces for the complex arithmetic unit.
// Depends on cau_pkg for the action code type.
`default_nettype none
interface cau_req_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    cau_pkg::action_t            action;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;

    modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic                        overflow;
    logic                        div_by_zero;

    modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
    modport sink   (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface
`default_nettype wire

### src/cau_front.sv
// Front end: products, combination and rounding/division setup in three stages.
// Depends on cau_pkg.
`default_nettype none
module cau_front #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int RW        = 98
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          en,
    input  wire                          valid_i,
    input  wire cau_pkg::action_t        action_i,
    input  wire logic signed [WORD_BITS-1:0] a_re,
    input  wire logic signed [WORD_BITS-1:0] a_im,
    input  wire logic signed [WORD_BITS-1:0] b_re,
    input  wire logic signed [WORD_BITS-1:0] b_im,
    output cau_pkg::cau_ctl_t            ctl_o,
    output logic [RW-1:0]                rem_re_o,
    output logic [RW-1:0]                rem_im_o,
    output logic [RW-1:0]                den_o,
    output logic [WORD_BITS-1:0]         side_re_o,
    output logic [WORD_BITS-1:0]         side_im_o
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W + 1;
    localparam logic signed [PW:0] HALF = ((PW+1)'(1) << FRAC_BITS) >> 1;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    // stage 1
    logic                    v1_reg;
    cau_pkg::action_t        act1_reg;
    logic signed [2*W-1:0]   prr_reg, pii_reg, pri_reg, pir_reg, qrr_reg, qii_reg;
    logic signed [2*W-1:0]   prr_next, pii_next, pri_next, pir_next, qrr_next, qii_next;
    logic signed [W:0]       sre1_reg, sim1_reg, sre1_next, sim1_next;

    // stage 2
    logic                    v2_reg;
    cau_pkg::action_t        act2_reg;
    logic signed [PW-1:0]    cre_reg, cim_reg, cre_next, cim_next;
    logic [2*W-1:0]          den2_reg, den2_next;
    logic signed [W:0]       sre2_reg, sim2_reg;

    // stage 3
    cau_pkg::cau_ctl_t       ctl_reg, ctl_next;
    logic [RW-1:0]           rem_re_reg, rem_im_reg, den_reg;
    logic [RW-1:0]           rem_re_next, rem_im_next, den_next;
    logic [W-1:0]            side_re_reg, side_im_reg, side_re_next, side_im_next;

    logic signed [PW:0]      rnd_re, rnd_im, mre, mim;
    logic [PW-1:0]           mag_re, mag_im;
    logic                    ov_re, ov_im;
    logic [W-1:0]            sat_re, sat_im;
    logic signed [PW:0]      src_re, src_im;

    always_comb
    begin
        prr_next = a_re * b_re;
        pii_next = a_im * b_im;
        pri_next = a_re * b_im;
        pir_next = a_im * b_re;
        qrr_next = b_re * b_re;
        qii_next = b_im * b_im;
        if (action_i == cau_pkg::ACT_SUB)
        begin
            sre1_next = (W+1)'(a_re) - (W+1)'(b_re);
            sim1_next = (W+1)'(a_im) - (W+1)'(b_im);
        end
        else
        begin
            sre1_next = (W+1)'(a_re) + (W+1)'(b_re);
            sim1_next = (W+1)'(a_im) + (W+1)'(b_im);
        end
    end

    always_comb
    begin
        den2_next = $unsigned(qrr_reg) + $unsigned(qii_reg);
        if (act1_reg == cau_pkg::ACT_DIV)
        begin
            cre_next = PW'(prr_reg) + PW'(pii_reg);
            cim_next = PW'(pir_reg) - PW'(pri_reg);
        end
        else
        begin
            cre_next = PW'(prr_reg) - PW'(pii_reg);
            cim_next = PW'(pri_reg) + PW'(pir_reg);
        end
    end

    always_comb
    begin
        rnd_re = (PW+1)'(cre_reg) + HALF;
        rnd_im = (PW+1)'(cim_reg) + HALF;
        mre    = rnd_re >>> FRAC_BITS;
        mim    = rnd_im >>> FRAC_BITS;
        mag_re = cre_reg[PW-1] ? $unsigned(-cre_reg) : $unsigned(cre_reg);
        mag_im = cim_reg[PW-1] ? $unsigned(-cim_reg) : $unsigned(cim_reg);

        if (act2_reg == cau_pkg::ACT_MUL)
        begin
            src_re = mre;
            src_im = mim;
        end
        else
        begin
            src_re = (PW+1)'(sre2_reg);
            src_im = (PW+1)'(sim2_reg);
        end
        ov_re  = !((&src_re[PW:W-1]) || !(|src_re[PW:W-1]));
        ov_im  = !((&src_im[PW:W-1]) || !(|src_im[PW:W-1]));
        sat_re = ov_re ? (src_re[PW] ? MINV : MAXV) : src_re[W-1:0];
        sat_im = ov_im ? (src_im[PW] ? MINV : MAXV) : src_im[W-1:0];

        rem_re_next = (RW'(mag_re) << (FRAC_BITS + 1)) + RW'(den2_reg);
        rem_im_next = (RW'(mag_im) << (FRAC_BITS + 1)) + RW'(den2_reg);
        den_next    = RW'(den2_reg) << (W + 1);

        ctl_next.valid    = v2_reg;
        ctl_next.is_div   = 1'b0;
        ctl_next.dz       = 1'b0;
        ctl_next.neg_re   = cre_reg[PW-1];
        ctl_next.neg_im   = cim_reg[PW-1];
        ctl_next.big_re   = rem_re_next >= (den_next << 1);
        ctl_next.big_im   = rem_im_next >= (den_next << 1);
        ctl_next.side_ovf = ov_re || ov_im;
        side_re_next      = sat_re;
        side_im_next      = sat_im;
        case (act2_reg)
            cau_pkg::ACT_ADD, cau_pkg::ACT_SUB, cau_pkg::ACT_MUL:
            begin
            end
            cau_pkg::ACT_DIV:
            begin
                ctl_next.is_div   = 1'b1;
                ctl_next.dz       = (den2_reg == '0);
                ctl_next.side_ovf = 1'b0;
                side_re_next      = '0;
                side_im_next      = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= valid_i;
            v2_reg  <= v1_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act1_reg    <= action_i;
            prr_reg     <= prr_next;
            pii_reg     <= pii_next;
            pri_reg     <= pri_next;
            pir_reg     <= pir_next;
            qrr_reg     <= qrr_next;
            qii_reg     <= qii_next;
            sre1_reg    <= sre1_next;
            sim1_reg    <= sim1_next;
            act2_reg    <= act1_reg;
            cre_reg     <= cre_next;
            cim_reg     <= cim_next;
            den2_reg    <= den2_next;
            sre2_reg    <= sre1_reg;
            sim2_reg    <= sim1_reg;
            rem_re_reg  <= rem_re_next;
            rem_im_reg  <= rem_im_next;
            den_reg     <= den_next;
            side_re_reg <= side_re_next;
            side_im_reg <= side_im_next;
        end
    end

    assign ctl_o     = ctl_reg;
    assign rem_re_o  = rem_re_reg;
    assign rem_im_o  = rem_im_reg;
    assign den_o     = den_reg;
    assign side_re_o = side_re_reg;
    assign side_im_o = side_im_reg;
endmodule
`default_nettype wire

### src/cau_div_cell.sv
// One restoring-division cell: one quotient bit for both lanes per cycle while en is high.
// Depends on cau_pkg for the control word.
`default_nettype none
module cau_div_cell #(
    parameter int WORD_BITS = 32,
    parameter int RW        = 98
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire cau_pkg::cau_ctl_t   ctl_i,
    input  wire [RW-1:0]             rem_re_i,
    input  wire [RW-1:0]             rem_im_i,
    input  wire [RW-1:0]             den_i,
    input  wire [WORD_BITS:0]        q_re_i,
    input  wire [WORD_BITS:0]        q_im_i,
    input  wire [WORD_BITS-1:0]      side_re_i,
    input  wire [WORD_BITS-1:0]      side_im_i,
    output cau_pkg::cau_ctl_t        ctl_o,
    output logic [RW-1:0]            rem_re_o,
    output logic [RW-1:0]            rem_im_o,
    output logic [RW-1:0]            den_o,
    output logic [WORD_BITS:0]       q_re_o,
    output logic [WORD_BITS:0]       q_im_o,
    output logic [WORD_BITS-1:0]     side_re_o,
    output logic [WORD_BITS-1:0]     side_im_o
);
    cau_pkg::cau_ctl_t    ctl_reg;
    logic [RW-1:0]        rem_re_reg, rem_im_reg, den_reg, rem_re_next, rem_im_next;
    logic [RW-1:0]        dif_re, dif_im;
    logic [WORD_BITS:0]   q_re_reg, q_im_reg;
    logic [WORD_BITS-1:0] side_re_reg, side_im_reg;
    logic                 ge_re, ge_im;

    always_comb
    begin
        ge_re       = rem_re_i >= den_i;
        ge_im       = rem_im_i >= den_i;
        dif_re      = ge_re ? rem_re_i - den_i : rem_re_i;
        dif_im      = ge_im ? rem_im_i - den_i : rem_im_i;
        rem_re_next = {dif_re[RW-2:0], 1'b0};
        rem_im_next = {dif_im[RW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_re_reg  <= rem_re_next;
            rem_im_reg  <= rem_im_next;
            den_reg     <= den_i;
            q_re_reg    <= {q_re_i[WORD_BITS-1:0], ge_re};
            q_im_reg    <= {q_im_i[WORD_BITS-1:0], ge_im};
            side_re_reg <= side_re_i;
            side_im_reg <= side_im_i;
        end
    end

    assign ctl_o     = ctl_reg;
    assign rem_re_o  = rem_re_reg;
    assign rem_im_o  = rem_im_reg;
    assign den_o     = den_reg;
    assign q_re_o    = q_re_reg;
    assign q_im_o    = q_im_reg;
    assign side_re_o = side_re_reg;
    assign side_im_o = side_im_reg;
endmodule
`default_nettype wire

### src/complex_arithmetic_unit.sv
// Complex add/sub/mul/div in signed fixed point with saturation.
// Pipeline: three front stages, one division cell per quotient bit, and one
// output register. Throughput: one transaction per cycle; the whole pipeline
// holds while a result waits on rsp.ready.
// Reset clears all valid bits; the unit accepts right after reset.
// Depends on cau_pkg, cau_if, cau_front and cau_div_cell.
`default_nettype none
module complex_arithmetic_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    cau_req_if.sink    req,
    cau_rsp_if.source  rsp
);
    localparam int W   = WORD_BITS;
    localparam int RWA = 3 * W + 2;
    localparam int RWB = 2 * W + FRAC_BITS + 2;
    localparam int RW  = (RWA > RWB) ? RWA : RWB;
    localparam int NC  = W + 1;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic en;

    cau_pkg::cau_ctl_t ctl_c [0:NC];
    logic [RW-1:0]     rem_re_c [0:NC];
    logic [RW-1:0]     rem_im_c [0:NC];
    logic [RW-1:0]     den_c [0:NC];
    logic [W:0]        q_re_c [0:NC];
    logic [W:0]        q_im_c [0:NC];
    logic [W-1:0]      side_re_c [0:NC];
    logic [W-1:0]      side_im_c [0:NC];

    logic              out_valid_reg;
    logic [W-1:0]      res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic              ovf_reg, ovf_next, dz_reg, dz_next;
    logic              sre, sim;
    logic [W:0]        qre, qim;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    cau_front #(
        .WORD_BITS(W),
        .FRAC_BITS(FRAC_BITS),
        .RW(RW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .valid_i(req.valid),
        .action_i(req.action),
        .a_re(req.a_re),
        .a_im(req.a_im),
        .b_re(req.b_re),
        .b_im(req.b_im),
        .ctl_o(ctl_c[0]),
        .rem_re_o(rem_re_c[0]),
        .rem_im_o(rem_im_c[0]),
        .den_o(den_c[0]),
        .side_re_o(side_re_c[0]),
        .side_im_o(side_im_c[0])
    );

    assign q_re_c[0] = '0;
    assign q_im_c[0] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        cau_div_cell #(
            .WORD_BITS(W),
            .RW(RW)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .en(en),
            .ctl_i(ctl_c[i]),
            .rem_re_i(rem_re_c[i]),
            .rem_im_i(rem_im_c[i]),
            .den_i(den_c[i]),
            .q_re_i(q_re_c[i]),
            .q_im_i(q_im_c[i]),
            .side_re_i(side_re_c[i]),
            .side_im_i(side_im_c[i]),
            .ctl_o(ctl_c[i+1]),
            .rem_re_o(rem_re_c[i+1]),
            .rem_im_o(rem_im_c[i+1]),
            .den_o(den_c[i+1]),
            .q_re_o(q_re_c[i+1]),
            .q_im_o(q_im_c[i+1]),
            .side_re_o(side_re_c[i+1]),
            .side_im_o(side_im_c[i+1])
        );
    end

    always_comb
    begin
        qre = q_re_c[NC];
        qim = q_im_c[NC];
        if (ctl_c[NC].neg_re)
        begin
            sre = ctl_c[NC].big_re || qre[W] || (qre[W-1] && (|qre[W-2:0]));
        end
        else
        begin
            sre = ctl_c[NC].big_re || qre[W] || qre[W-1];
        end
        if (ctl_c[NC].neg_im)
        begin
            sim = ctl_c[NC].big_im || qim[W] || (qim[W-1] && (|qim[W-2:0]));
        end
        else
        begin
            sim = ctl_c[NC].big_im || qim[W] || qim[W-1];
        end

        res_re_next = side_re_c[NC];
        res_im_next = side_im_c[NC];
        ovf_next    = ctl_c[NC].side_ovf;
        dz_next     = 1'b0;
        if (ctl_c[NC].is_div)
        begin
            if (ctl_c[NC].dz)
            begin
                res_re_next = '0;
                res_im_next = '0;
                ovf_next    = 1'b0;
                dz_next     = 1'b1;
            end
            else
            begin
                if (sre)
                    res_re_next = ctl_c[NC].neg_re ? MINV : MAXV;
                else
                    res_re_next = ctl_c[NC].neg_re ? -qre[W-1:0] : qre[W-1:0];
                if (sim)
                    res_im_next = ctl_c[NC].neg_im ? MINV : MAXV;
                else
                    res_im_next = ctl_c[NC].neg_im ? -qim[W-1:0] : qim[W-1:0];
                ovf_next = sre || sim;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_c[NC].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            ovf_reg    <= ovf_next;
            dz_reg     <= dz_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.res_re      = res_re_reg;
    assign rsp.res_im      = res_im_reg;
    assign rsp.overflow    = ovf_reg;
    assign rsp.div_by_zero = dz_reg;
endmodule
`default_nettype wire

### src/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on complex_arithmetic_unit ports only.
`default_nettype none
module cau_checker #(
    parameter int WORD_BITS = 32
) (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 req_ready,
    input wire                 rsp_valid,
    input wire                 rsp_ready,
    input wire [WORD_BITS-1:0] res_re,
    input wire [WORD_BITS-1:0] res_im,
    input wire                 overflow,
    input wire                 div_by_zero
);
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("req ready does not track output register state");

    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && div_by_zero) |-> (res_re == '0 && res_im == '0 && !overflow))
        else $error("divide-by-zero transaction carries nonzero result or overflow");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(res_re) && $stable(res_im)
            && $stable(overflow) && $stable(div_by_zero)))
        else $error("stalled result transaction changed");
endmodule

bind complex_arithmetic_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .res_re(rsp.res_re),
    .res_im(rsp.res_im),
    .overflow(rsp.overflow),
    .div_by_zero(rsp.div_by_zero)
);
`default_nettype wire
